[sv/scsa_pkg.sv]
// Shared constants and types for the size class slab allocator.
// Depends on nothing; imported by the allocator top level.
package scsa_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int NUM_CLASSES_DEF      = 4;
  localparam int CHUNKS_PER_CLASS_DEF = 8;
  localparam int MAX_ENTRIES_DEF      = 64;
  localparam int HEADER_BYTES_DEF     = 4;

  // Configuration register file.
  localparam int CFG_CLASSES = 4;
  localparam int CAP_W       = 13;
  localparam int ENT_W       = 7;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;
  localparam logic [2:0] REG_CAP0 = 3'd0;
  localparam logic [2:0] REG_ENT0 = 3'd4;

  // Counters.
  localparam int USED_W    = 7;
  localparam int USED_MAX  = 127;
  localparam int AVAIL_W   = 10;
  localparam int AVAIL_MAX = 1023;
  localparam int WATERMARK = 2;

  // Field widths.
  localparam int REQ_W    = 16;
  localparam int STATUS_W = 3;
  localparam int OCLS_W   = 2;
  localparam int OCHK_W   = 3;
  localparam int OENT_W   = 6;

  // Commands.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ALLOC    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXTERNAL = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EXT_FREE = 3'd5;

  // Edits of a class's chunk list.
  typedef enum logic [1:0] {
    LOP_NONE,
    LOP_FRONT,
    LOP_REMOVE,
    LOP_PUSH
  } list_op_e;

endpackage

[sv/size_class_slab_allocator_top.sv]
// Size class slab allocator: allocate and free entries from up to four size classes.
// Depends on scsa_pkg and on scsa_ram for the slot record and entry link memories.
//
//   channel   direction  handshake                  payload
//   in        input      in_valid_i / in_ready_o    command, request_bytes, handle_*
//   out       output     out_valid_o / out_ready_i  status, class/chunk/entry index
//   config    input      psel/penable/pwrite/pready paddr, pwdata, prdata (read back)
//
// One item is worked on at a time. A zero-size, external or unfitting allocate, an
// external free and a free of a chunk that is not open go from dispatch straight to
// the done state; any other free passes a free check first. An allocate probes the
// class list chunk by chunk (one slot memory read and its check), then reads and
// rewrites the chosen slot record; opening a new chunk first sweeps its free list
// into the link memory one entry a cycle. Reset clears all control state at once;
// there is no clearing pass because each chunk slot's open flag marks its record valid.
// A finished result waits in the output register while the next item is taken in.
module size_class_slab_allocator_top #(
  parameter int NUM_CLASSES      = scsa_pkg::NUM_CLASSES_DEF,
  parameter int CHUNKS_PER_CLASS = scsa_pkg::CHUNKS_PER_CLASS_DEF,
  parameter int MAX_ENTRIES      = scsa_pkg::MAX_ENTRIES_DEF,
  parameter int HEADER_BYTES     = scsa_pkg::HEADER_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input items
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           command_i,
  input  logic [scsa_pkg::REQ_W-1:0]     request_bytes_i,
  input  logic                           handle_external_i,
  input  logic [scsa_pkg::OCLS_W-1:0]    handle_class_i,
  input  logic [scsa_pkg::OCHK_W-1:0]    handle_chunk_i,
  input  logic [scsa_pkg::OENT_W-1:0]    handle_entry_i,
  // Result items
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [scsa_pkg::STATUS_W-1:0]  status_o,
  output logic [scsa_pkg::OCLS_W-1:0]    class_index_o,
  output logic [scsa_pkg::OCHK_W-1:0]    chunk_index_o,
  output logic [scsa_pkg::OENT_W-1:0]    entry_index_o,
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [scsa_pkg::PADDR_W-1:0]   paddr,
  input  logic [scsa_pkg::PDATA_W-1:0]   pwdata,
  output logic [scsa_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import scsa_pkg::*;

  localparam int NSLOT = NUM_CLASSES * CHUNKS_PER_CLASS;
  localparam int CW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int KW    = (CHUNKS_PER_CLASS > 1) ? $clog2(CHUNKS_PER_CLASS) : 1;
  localparam int LNW   = $clog2(CHUNKS_PER_CLASS + 1);
  localparam int SW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int EW    = $clog2(MAX_ENTRIES);
  localparam int HW    = $clog2(MAX_ENTRIES + 1);
  localparam int LDEP  = NSLOT * MAX_ENTRIES;
  localparam int LW    = $clog2(LDEP);
  localparam int SRW   = USED_W + HW;
  localparam int LIM_W = HW + 2;
  localparam int SZ_W  = REQ_W + 1;
  localparam int NCLS  = (NUM_CLASSES < CFG_CLASSES) ? NUM_CLASSES : CFG_CLASSES;
  localparam logic [HW-1:0]     NULL_MARK = HW'(MAX_ENTRIES);
  localparam logic [LNW-1:0]    LEN_FULL  = LNW'(CHUNKS_PER_CLASS);
  localparam logic [USED_W-1:0] USED_TOP  = USED_W'(USED_MAX);
  localparam logic [AVAIL_W-1:0] AVAIL_TOP = AVAIL_W'(AVAIL_MAX);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_PROBE = 4'd2;
  localparam logic [3:0] S_PCHK  = 4'd3;
  localparam logic [3:0] S_NEW   = 4'd4;
  localparam logic [3:0] S_SWEEP = 4'd5;
  localparam logic [3:0] S_POPRD = 4'd6;
  localparam logic [3:0] S_POPWR = 4'd7;
  localparam logic [3:0] S_FCHK  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  // Configuration registers.
  logic [CAP_W-1:0] capacity_q [CFG_CLASSES];
  logic [ENT_W-1:0] entries_q  [CFG_CLASSES];
  logic             cfg_we;
  logic [2:0]       reg_ix;

  // Control state.
  logic [3:0]         state_q, state_d;
  logic [LNW-1:0]     len_q [NUM_CLASSES];
  logic [KW-1:0]      order_q [NUM_CLASSES][CHUNKS_PER_CLASS];
  logic [NSLOT-1:0]   open_q;
  logic [AVAIL_W-1:0] avail_q [NUM_CLASSES];

  // Captured item and working registers.
  logic               cmd_q, ext_q;
  logic [REQ_W-1:0]   req_q;
  logic [OCLS_W-1:0]  hcls_q;
  logic [OCHK_W-1:0]  hchk_q;
  logic [OENT_W-1:0]  hent_q;
  logic [OCLS_W-1:0]  cls_q, cls_d;
  logic [KW-1:0]      slot_q, slot_d;
  logic [LNW-1:0]     pi_q, pi_d;
  logic [HW-1:0]      head_q, head_d;
  logic [USED_W-1:0]  used_q, used_d;
  logic [HW-1:0]      sw_q, sw_d;
  logic [STATUS_W-1:0] res_st_q, res_st_d;

  // Output register.
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_st_q;
  logic [OCLS_W-1:0]   out_cls_q;
  logic [OCHK_W-1:0]   out_chk_q;
  logic [OENT_W-1:0]   out_ent_q;
  logic                out_load;

  // Memory ports.
  logic           sr_we;
  logic [SW-1:0]  sr_waddr, sr_raddr;
  logic [SRW-1:0] sr_wdata, sr_rdata;
  logic [USED_W-1:0] sr_used;
  logic [HW-1:0]  sr_head;
  logic           lk_we;
  logic [LW-1:0]  lk_waddr, lk_raddr;
  logic [HW-1:0]  lk_wdata, lk_rdata;

  // Derived values.
  logic [CW-1:0]  cix;
  logic [SW-1:0]  cur_idx, free_idx, probe_idx;
  logic [HW-1:0]  n_sel;
  logic [SZ_W-1:0] req_sz;
  logic           cls_found;
  logic [OCLS_W-1:0] cls_hit;
  logic           nfree_found;
  logic [KW-1:0]  nfree_slot;
  logic           free_ok;
  logic [HW:0]    sw_next;
  logic [LIM_W-1:0] limit;
  logic [AVAIL_W:0] av_sum;
  logic [AVAIL_W-1:0] av_inc;
  logic [USED_W-1:0] used_dec;
  logic [HW-1:0]  pop_next;

  // List edit.
  list_op_e       lop;
  logic [KW-1:0]  row [CHUNKS_PER_CLASS];
  logic [KW-1:0]  new_row [CHUNKS_PER_CLASS];
  logic [LNW-1:0] new_len;
  logic           pos_found;
  logic [KW-1:0]  pos;

  // Counter updates.
  logic               avail_we, open_set, open_clr;
  logic [AVAIL_W-1:0] avail_new;

  // ---------------------------------------------------------------------------
  // Configuration port: registers at byte address 4*i, always ready.
  assign pready = 1'b1;
  assign reg_ix = paddr[4:2];
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CFG_CLASSES; i++) begin
        capacity_q[i] <= '0;
        entries_q[i]  <= ENT_W'(1);
      end
    end else if (cfg_we) begin
      if (reg_ix < REG_ENT0) begin
        capacity_q[reg_ix[1:0]] <= pwdata[CAP_W-1:0];
      end else begin
        entries_q[reg_ix[1:0]] <= pwdata[ENT_W-1:0];
      end
    end
  end

  always_comb begin
    if (reg_ix < REG_ENT0) begin
      prdata = PDATA_W'(capacity_q[reg_ix[1:0]]);
    end else begin
      prdata = PDATA_W'(entries_q[reg_ix[1:0]]);
    end
  end

  // ---------------------------------------------------------------------------
  // Memories: slot record {used count, free list head} and the entry links.
  scsa_ram #(.WIDTH(SRW), .DEPTH(NSLOT)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (sr_we),
    .waddr_i (sr_waddr),
    .wdata_i (sr_wdata),
    .raddr_i (sr_raddr),
    .rdata_o (sr_rdata)
  );

  scsa_ram #(.WIDTH(HW), .DEPTH(LDEP)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lk_we),
    .waddr_i (lk_waddr),
    .wdata_i (lk_wdata),
    .raddr_i (lk_raddr),
    .rdata_o (lk_rdata)
  );

  assign sr_used = sr_rdata[SRW-1:HW];
  assign sr_head = sr_rdata[HW-1:0];

  // ---------------------------------------------------------------------------
  // Address and size arithmetic.
  assign cix       = CW'(cls_q);
  assign cur_idx   = SW'(32'(cls_q) * CHUNKS_PER_CLASS + 32'(slot_q));
  assign free_idx  = SW'(32'(hcls_q) * CHUNKS_PER_CLASS + 32'(hchk_q));
  assign probe_idx = SW'(32'(cls_q) * CHUNKS_PER_CLASS + 32'(order_q[cix][pi_q[KW-1:0]]));
  assign sr_raddr  = (state_q == S_DISP) ? free_idx : probe_idx;
  assign lk_raddr  = LW'(32'(cur_idx) * MAX_ENTRIES + 32'(head_q));
  assign req_sz    = SZ_W'(req_q) + SZ_W'(HEADER_BYTES);
  assign sw_next   = {1'b0, sw_q} + 1'b1;
  assign pop_next  = (lk_rdata < NULL_MARK) ? lk_rdata : NULL_MARK;
  assign used_dec  = sr_used - 1'b1;
  assign av_sum    = {1'b0, avail_q[cix]} + 1'b1;
  assign av_inc    = (av_sum > (AVAIL_W+1)'(AVAIL_MAX)) ? AVAIL_TOP : av_sum[AVAIL_W-1:0];
  assign free_ok   = (32'(hent_q) < 32'(n_sel)) && (sr_used != '0);

  // Entries per chunk of the working class, clamped to one and to the maximum.
  always_comb begin
    if (entries_q[cls_q] == '0) begin
      n_sel = HW'(1);
    end else if (32'(entries_q[cls_q]) > MAX_ENTRIES) begin
      n_sel = NULL_MARK;
    end else begin
      n_sel = HW'(entries_q[cls_q]);
    end
  end

  // Release threshold for an emptied chunk.
  always_comb begin
    if (n_sel > HW'(1)) begin
      limit = LIM_W'((WATERMARK - 1) * 32'(n_sel) / WATERMARK + 32'(n_sel));
    end else begin
      limit = LIM_W'(WATERMARK);
    end
  end

  // First class, before any disabled (zero capacity) one, whose capacity holds the request plus header.
  always_comb begin
    logic stop;
    cls_found = 1'b0;
    cls_hit   = '0;
    stop      = 1'b0;
    for (int c = 0; c < NCLS; c++) begin
      if (!stop) begin
        if (capacity_q[c] == '0) begin
          stop = 1'b1;
        end else if (req_sz <= SZ_W'(capacity_q[c])) begin
          cls_found = 1'b1;
          cls_hit   = OCLS_W'(c);
          stop      = 1'b1;
        end
      end
    end
  end

  // First unopened chunk slot of the working class.
  always_comb begin
    nfree_found = 1'b0;
    nfree_slot  = '0;
    for (int j = 0; j < CHUNKS_PER_CLASS; j++) begin
      if (!nfree_found && !open_q[32'(cls_q) * CHUNKS_PER_CLASS + j]) begin
        nfree_found = 1'b1;
        nfree_slot  = KW'(j);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  always_comb begin
    state_d   = state_q;
    cls_d     = cls_q;
    slot_d    = slot_q;
    pi_d      = pi_q;
    head_d    = head_q;
    used_d    = used_q;
    sw_d      = sw_q;
    res_st_d  = res_st_q;
    sr_we     = 1'b0;
    sr_waddr  = cur_idx;
    sr_wdata  = '0;
    lk_we     = 1'b0;
    lk_waddr  = '0;
    lk_wdata  = '0;
    lop       = LOP_NONE;
    avail_we  = 1'b0;
    avail_new = avail_q[cix];
    open_set  = 1'b0;
    open_clr  = 1'b0;
    out_load  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_DONE;
        if (cmd_q == CMD_ALLOC) begin
          if (req_q == '0) begin
            res_st_d = ST_ZERO;
          end else if (!cls_found) begin
            res_st_d = ST_EXTERNAL;
          end else begin
            cls_d = cls_hit;
            pi_d  = '0;
            if (len_q[CW'(cls_hit)] == '0) begin
              state_d = S_NEW;
            end else begin
              state_d = S_PROBE;
            end
          end
        end else if (ext_q) begin
          res_st_d = ST_EXT_FREE;
        end else begin
          res_st_d = ST_FREED;
          cls_d    = hcls_q;
          slot_d   = KW'(hchk_q);
          if ((32'(hcls_q) < NUM_CLASSES) && (32'(hchk_q) < CHUNKS_PER_CLASS) &&
              open_q[free_idx]) begin
            state_d = S_FCHK;
          end
        end
      end
      S_PROBE: begin
        state_d = S_PCHK;
      end
      S_PCHK: begin
        if (sr_head != NULL_MARK) begin
          slot_d  = order_q[cix][pi_q[KW-1:0]];
          head_d  = sr_head;
          used_d  = sr_used;
          state_d = S_POPRD;
        end else begin
          pi_d = pi_q + 1'b1;
          if (pi_q + 1'b1 == len_q[cix]) begin
            state_d = S_NEW;
          end else begin
            state_d = S_PROBE;
          end
        end
      end
      S_NEW: begin
        if ((len_q[cix] < LEN_FULL) && nfree_found) begin
          slot_d  = nfree_slot;
          sw_d    = '0;
          state_d = S_SWEEP;
        end else begin
          res_st_d = ST_EXTERNAL;
          state_d  = S_DONE;
        end
      end
      S_SWEEP: begin
        // Build the fresh chunk's free list: entry e links to e+1, the last to null.
        lk_we    = 1'b1;
        lk_waddr = LW'(32'(cur_idx) * MAX_ENTRIES + 32'(sw_q[EW-1:0]));
        lk_wdata = (sw_next < {1'b0, n_sel}) ? sw_next[HW-1:0] : NULL_MARK;
        sw_d     = sw_next[HW-1:0];
        if (sw_next == {1'b0, n_sel}) begin
          open_set  = 1'b1;
          lop       = LOP_PUSH;
          avail_we  = 1'b1;
          if ((32'(avail_q[cix]) + 32'(n_sel)) > AVAIL_MAX) begin
            avail_new = AVAIL_TOP;
          end else begin
            avail_new = avail_q[cix] + AVAIL_W'(n_sel);
          end
          head_d  = '0;
          used_d  = '0;
          state_d = S_POPRD;
        end
      end
      S_POPRD: begin
        state_d = S_POPWR;
      end
      S_POPWR: begin
        sr_we    = 1'b1;
        sr_wdata = {((used_q == USED_TOP) ? USED_TOP : used_q + 1'b1), pop_next};
        avail_we = 1'b1;
        avail_new = (avail_q[cix] != '0) ? avail_q[cix] - 1'b1 : '0;
        if (pop_next != NULL_MARK) begin
          lop = LOP_FRONT;
        end
        res_st_d = ST_ALLOC;
        state_d  = S_DONE;
      end
      S_FCHK: begin
        state_d = S_DONE;
        if (free_ok) begin
          lk_we     = 1'b1;
          lk_waddr  = LW'(32'(cur_idx) * MAX_ENTRIES + 32'(hent_q));
          lk_wdata  = sr_head;
          sr_we     = 1'b1;
          sr_wdata  = {used_dec, HW'(hent_q)};
          avail_we  = 1'b1;
          avail_new = av_inc;
          lop       = LOP_FRONT;
          if ((used_dec == '0) && (av_inc > AVAIL_W'(limit))) begin
            // Chunk emptied with enough spare entries elsewhere: give it back.
            lop       = LOP_REMOVE;
            open_clr  = 1'b1;
            sr_wdata  = {used_dec, NULL_MARK};
            avail_new = (av_inc > AVAIL_W'(n_sel)) ? av_inc - AVAIL_W'(n_sel) : '0;
            res_st_d  = ST_RELEASED;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  // ---------------------------------------------------------------------------
  // Chunk list edit on the working class: move to front, remove or push in front.
  always_comb begin
    for (int j = 0; j < CHUNKS_PER_CLASS; j++) begin
      row[j] = order_q[cix][j];
    end
    pos_found = 1'b0;
    pos       = '0;
    for (int j = 0; j < CHUNKS_PER_CLASS; j++) begin
      if (!pos_found && (32'(len_q[cix]) > j) && (row[j] == slot_q)) begin
        pos_found = 1'b1;
        pos       = KW'(j);
      end
    end
    new_row = row;
    new_len = len_q[cix];
    case (lop)
      LOP_FRONT: begin
        if (pos_found) begin
          for (int j = 0; j < CHUNKS_PER_CLASS; j++) begin
            if (j == 0) begin
              new_row[j] = slot_q;
            end else if (j <= 32'(pos)) begin
              new_row[j] = row[j-1];
            end
          end
        end
      end
      LOP_REMOVE: begin
        if (pos_found) begin
          for (int j = 0; j + 1 < CHUNKS_PER_CLASS; j++) begin
            if (j >= 32'(pos)) begin
              new_row[j] = row[j+1];
            end
          end
          new_len = len_q[cix] - 1'b1;
        end
      end
      LOP_PUSH: begin
        if (len_q[cix] < LEN_FULL) begin
          for (int j = 0; j < CHUNKS_PER_CLASS; j++) begin
            if (j == 0) begin
              new_row[j] = slot_q;
            end else begin
              new_row[j] = row[j-1];
            end
          end
          new_len = len_q[cix] + 1'b1;
        end
      end
      default: begin
        new_len = len_q[cix];
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      open_q      <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        len_q[c]   <= '0;
        avail_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (lop != LOP_NONE) begin
        len_q[cix] <= new_len;
      end
      if (avail_we) begin
        avail_q[cix] <= avail_new;
      end
      if (open_set) begin
        open_q[cur_idx] <= 1'b1;
      end else if (open_clr) begin
        open_q[cur_idx] <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and list contents need no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= command_i;
      req_q  <= request_bytes_i;
      ext_q  <= handle_external_i;
      hcls_q <= handle_class_i;
      hchk_q <= handle_chunk_i;
      hent_q <= handle_entry_i;
    end
    cls_q    <= cls_d;
    slot_q   <= slot_d;
    pi_q     <= pi_d;
    head_q   <= head_d;
    used_q   <= used_d;
    sw_q     <= sw_d;
    res_st_q <= res_st_d;
    if (lop != LOP_NONE) begin
      for (int j = 0; j < CHUNKS_PER_CLASS; j++) begin
        order_q[cix][j] <= new_row[j];
      end
    end
    if (out_load) begin
      out_st_q <= res_st_q;
      if (res_st_q == ST_ALLOC) begin
        out_cls_q <= cls_q;
        out_chk_q <= OCHK_W'(slot_q);
        out_ent_q <= OENT_W'(head_q);
      end else begin
        out_cls_q <= '0;
        out_chk_q <= '0;
        out_ent_q <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_st_q;
  assign class_index_o = out_cls_q;
  assign chunk_index_o = out_chk_q;
  assign entry_index_o = out_ent_q;

  // ---------------------------------------------------------------------------
  // Assertions.

  // An entry is only ever popped from an open chunk.
  a_pop_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POPWR) |-> open_q[cur_idx])
    else $error("entry popped from a chunk that is not open");

  // The free list sweep stays inside the chunk.
  a_sweep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP) |-> (sw_q < n_sel))
    else $error("chunk sweep ran past the entries per chunk");

  // Every class's chunk list is as long as its count of open chunk slots.
  for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_len_chk
    a_len_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $countones(open_q[g*CHUNKS_PER_CLASS +: CHUNKS_PER_CLASS]) == 32'(len_q[g]))
      else $error("chunk list length differs from open chunk count");
  end

endmodule

[sv/scsa_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing; used for the slot records and the entry links.
module scsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sim/scsa_checker.sv]
// Checker for the size class slab allocator: predicts each result from accepted items.
// Depends on scsa_pkg; instantiated beside the allocator by the testbench top.
module scsa_checker
  import scsa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                command_i,
  input  logic [REQ_W-1:0]    request_bytes_i,
  input  logic                handle_external_i,
  input  logic [OCLS_W-1:0]   handle_class_i,
  input  logic [OCHK_W-1:0]   handle_chunk_i,
  input  logic [OENT_W-1:0]   handle_entry_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [STATUS_W-1:0] status_i,
  input  logic [OCLS_W-1:0]   class_index_i,
  input  logic [OCHK_W-1:0]   chunk_index_i,
  input  logic [OENT_W-1:0]   entry_index_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCLS = NUM_CLASSES_DEF;
  localparam int NCHK = CHUNKS_PER_CLASS_DEF;
  localparam int NENT = MAX_ENTRIES_DEF;
  localparam int HDR  = HEADER_BYTES_DEF;
  localparam int NSLOT = NCLS * NCHK;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OCLS_W-1:0]   cls;
    logic [OCHK_W-1:0]   chk;
    logic [OENT_W-1:0]   ent;
  } result_t;

  result_t expected_results[$];

  logic [CAP_W-1:0] cap_q [CFG_CLASSES];
  logic [ENT_W-1:0] ent_q [CFG_CLASSES];
  int order_q [NSLOT];
  int len_q [NCLS];
  bit open_q [NSLOT];
  int used_q [NSLOT];
  int head_q [NSLOT];
  int link_q [NSLOT*NENT];
  int avail_q [NCLS];

  function automatic int per_chunk(int c);
    int v;
    v = ent_q[c];
    if (v < 1) v = 1;
    if (v > NENT) v = NENT;
    return v;
  endfunction

  function automatic int pos_of(int c, int s);
    for (int i = 0; i < len_q[c]; i++)
      if (order_q[c*NCHK+i] == s) return i;
    return -1;
  endfunction

  function automatic void unlink(int c, int s);
    int p;
    p = pos_of(c, s);
    if (p < 0) return;
    for (int i = p; i + 1 < len_q[c]; i++) order_q[c*NCHK+i] = order_q[c*NCHK+i+1];
    len_q[c]--;
  endfunction

  function automatic void push_front(int c, int s);
    if (len_q[c] >= NCHK) return;
    for (int i = len_q[c]; i > 0; i--) order_q[c*NCHK+i] = order_q[c*NCHK+i-1];
    order_q[c*NCHK] = s;
    len_q[c]++;
  endfunction

  function automatic void to_front(int c, int s);
    if (pos_of(c, s) <= 0) return;
    unlink(c, s);
    push_front(c, s);
  endfunction

  // Walks the allocator state exactly as the block should and returns one result.
  function automatic result_t allocate_or_free(bit cmd, int req, bit ext, int c, int s, int e);
    result_t r;
    int cls, slot, idx, n, lim;
    bit found;
    r = '0;
    if (cmd == CMD_ALLOC) begin
      if (req == 0) begin
        r.status = ST_ZERO;
        return r;
      end
      cls = -1;
      for (int k = 0; k < NCLS; k++) begin
        if (cap_q[k] == 0) break;
        if (req + HDR <= cap_q[k]) begin
          cls = k;
          break;
        end
      end
      r.status = ST_EXTERNAL;
      if (cls < 0) return r;
      found = 0;
      slot = 0;
      for (int i = 0; i < len_q[cls]; i++) begin
        if (head_q[cls*NCHK+order_q[cls*NCHK+i]] < NENT) begin
          slot = order_q[cls*NCHK+i];
          found = 1;
          break;
        end
      end
      if (!found && len_q[cls] < NCHK) begin
        for (int i = 0; i < NCHK; i++) begin
          if (!open_q[cls*NCHK+i]) begin
            n = per_chunk(cls);
            idx = cls*NCHK + i;
            for (int k = 0; k + 1 < n; k++) link_q[idx*NENT+k] = k + 1;
            link_q[idx*NENT+n-1] = NENT;
            head_q[idx] = 0;
            used_q[idx] = 0;
            open_q[idx] = 1;
            avail_q[cls] = (avail_q[cls] + n > AVAIL_MAX) ? AVAIL_MAX : avail_q[cls] + n;
            push_front(cls, i);
            slot = i;
            found = 1;
            break;
          end
        end
      end
      if (!found) return r;
      idx = cls*NCHK + slot;
      e = head_q[idx];
      head_q[idx] = (link_q[idx*NENT+e] < NENT) ? link_q[idx*NENT+e] : NENT;
      if (used_q[idx] < USED_MAX) used_q[idx]++;
      if (avail_q[cls] > 0) avail_q[cls]--;
      if (head_q[idx] < NENT) to_front(cls, slot);
      r.status = ST_ALLOC;
      r.cls = OCLS_W'(cls);
      r.chk = OCHK_W'(slot);
      r.ent = OENT_W'(e);
      return r;
    end
    if (ext) begin
      r.status = ST_EXT_FREE;
      return r;
    end
    r.status = ST_FREED;
    idx = c*NCHK + s;
    n = per_chunk(c);
    if (!open_q[idx] || e >= n || used_q[idx] == 0) return r;
    link_q[idx*NENT+e] = head_q[idx];
    head_q[idx] = e;
    if (avail_q[c] < AVAIL_MAX) avail_q[c]++;
    to_front(c, s);
    used_q[idx]--;
    if (used_q[idx] == 0) begin
      lim = (n > 1) ? ((WATERMARK - 1) * n) / WATERMARK + n : WATERMARK;
      if (avail_q[c] > lim) begin
        unlink(c, s);
        open_q[idx] = 0;
        head_q[idx] = NENT;
        avail_q[c] = (avail_q[c] > n) ? avail_q[c] - n : 0;
        r.status = ST_RELEASED;
      end
    end
    return r;
  endfunction

  assign pending_o = expected_results.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      expected_results.delete();
      for (int i = 0; i < CFG_CLASSES; i++) begin
        cap_q[i] = '0;
        ent_q[i] = 7'd1;
      end
      for (int i = 0; i < NSLOT; i++) begin
        open_q[i] = 0;
        used_q[i] = 0;
        head_q[i] = NENT;
        order_q[i] = 0;
      end
      for (int i = 0; i < NCLS; i++) begin
        len_q[i] = 0;
        avail_q[i] = 0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i < REG_ENT0) cap_q[cfg_idx_i[1:0]] = cfg_data_i[CAP_W-1:0];
        else ent_q[cfg_idx_i[1:0]] = cfg_data_i[ENT_W-1:0];
      end
      if (out_valid_i && out_ready_i) begin
        got = '{status_i, class_index_i, chunk_index_i, entry_index_i};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected st=%0d c=%0d k=%0d e=%0d, actual st=%0d c=%0d k=%0d e=%0d",
                     $time, want.status, want.cls, want.chk, want.ent,
                     got.status, got.cls, got.chk, got.ent);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_results.push_back(allocate_or_free(command_i, request_bytes_i,
            handle_external_i, handle_class_i, handle_chunk_i, handle_entry_i));
    end
  end
endmodule

[sim/tb_size_class_slab_allocator_top.sv]
// Testbench top for the size class slab allocator: stimulus, APB setup and verdict.
// Depends on scsa_pkg, the allocator RTL and scsa_checker.
module tb_size_class_slab_allocator_top;
  import scsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic command = CMD_ALLOC;
  logic [REQ_W-1:0] request_bytes = '0;
  logic handle_external = 1'b0;
  logic [OCLS_W-1:0] handle_class = '0;
  logic [OCHK_W-1:0] handle_chunk = '0;
  logic [OENT_W-1:0] handle_entry = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [OCLS_W-1:0] class_index;
  logic [OCHK_W-1:0] chunk_index;
  logic [OENT_W-1:0] entry_index;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  int fail_count;
  int pending;

  // Live handles of entries we were granted, so frees usually target real entries.
  typedef struct packed {
    logic [1:0] cls;
    logic [2:0] chk;
    logic [5:0] ent;
  } handle_t;
  handle_t live_handles[$];
  int stall_mode;

  // Clock with a 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  size_class_slab_allocator_top u_top (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .command_i(command), .request_bytes_i(request_bytes),
    .handle_external_i(handle_external), .handle_class_i(handle_class),
    .handle_chunk_i(handle_chunk), .handle_entry_i(handle_entry),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .class_index_o(class_index),
    .chunk_index_o(chunk_index), .entry_index_o(entry_index),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // The checker sees a register write on the same edge the block takes it.
  scsa_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .command_i(command), .request_bytes_i(request_bytes),
    .handle_external_i(handle_external), .handle_class_i(handle_class),
    .handle_chunk_i(handle_chunk), .handle_entry_i(handle_entry),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .status_i(status), .class_index_i(class_index),
    .chunk_index_i(chunk_index), .entry_index_i(entry_index),
    .cfg_we_i(psel && penable && pwrite && pready),
    .cfg_idx_i(paddr[4:2]), .cfg_data_i(pwdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // The receiver stalls on a pattern that changes mode every so often: always
  // ready, random stalls, or long stretches held off.
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // Collect granted handles for later frees; this watches the output side only.
  always @(posedge clk_i) begin
    if (out_valid && out_ready && status == ST_ALLOC)
      live_handles.push_back('{class_index, chunk_index, entry_index});
  end

  task automatic reg_write(input int idx, input int value);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= PADDR_W'(idx * 4);
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Drives one item and holds it until the block takes it.
  task automatic send_item(input bit cmd, input int req, input bit ext,
                           input int c, input int k, input int e);
    command <= cmd;
    request_bytes <= REQ_W'(req);
    handle_external <= ext;
    handle_class <= OCLS_W'(c);
    handle_chunk <= OCHK_W'(k);
    handle_entry <= OENT_W'(e);
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  // Waits out all results, then a margin for any item still in flight.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic set_classes(input int c0, input int c1, input int c2, input int c3,
                             input int n0, input int n1, input int n2, input int n3);
    reg_write(REG_CAP0 + 0, c0);
    reg_write(REG_CAP0 + 1, c1);
    reg_write(REG_CAP0 + 2, c2);
    reg_write(REG_CAP0 + 3, c3);
    reg_write(REG_ENT0 + 0, n0);
    reg_write(REG_ENT0 + 1, n1);
    reg_write(REG_ENT0 + 2, n2);
    reg_write(REG_ENT0 + 3, n3);
  endtask

  // One random item: mostly allocates and frees of live handles, some noise.
  task automatic random_item();
    int pick, j;
    handle_t h;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      send_item(CMD_ALLOC, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                : $urandom_range(1, 300), 1'b0, $urandom, $urandom, $urandom);
    end else if (pick < 85 && live_handles.size() > 0) begin
      j = $urandom_range(0, live_handles.size() - 1);
      h = live_handles[j];
      live_handles.delete(j);
      send_item(CMD_FREE, $urandom, 1'b0, h.cls, h.chk, h.ent);
    end else if (pick < 92) begin
      send_item(CMD_FREE, $urandom, 1'b1, $urandom, $urandom, $urandom);
    end else begin
      send_item(CMD_FREE, $urandom, 1'b0, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    int burst;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With reset settings a nonzero allocate goes external and a zero one reports zero size.
    send_item(CMD_ALLOC, 1, 1'b0, 0, 0, 0);
    send_item(CMD_ALLOC, 0, 1'b0, 0, 0, 0);
    drain();

    // Small chunks exercise release; zero and maximum entry counts are clipped.
    set_classes(8, 64, 4096, 0, 1, 2, 127, 0);
    send_item(CMD_ALLOC, 0, 1'b0, 3, 7, 63);
    send_item(CMD_ALLOC, 65535, 1'b0, 0, 0, 0);
    send_item(CMD_ALLOC, 4092, 1'b0, 0, 0, 0);
    send_item(CMD_ALLOC, 4093, 1'b0, 0, 0, 0);
    for (int i = 0; i < 10; i++) send_item(CMD_ALLOC, 4, 1'b0, 0, 0, 0);
    send_item(CMD_ALLOC, 60, 1'b0, 0, 0, 0);
    send_item(CMD_FREE, 0, 1'b1, 3, 7, 63);
    send_item(CMD_FREE, 0, 1'b0, 3, 7, 63);
    send_item(CMD_FREE, 0, 1'b0, 0, 0, 0);
    send_item(CMD_FREE, 0, 1'b0, 0, 0, 0);
    send_item(CMD_FREE, 0, 1'b0, 0, 1, 0);
    send_item(CMD_FREE, 0, 1'b0, 0, 2, 0);
    send_item(CMD_FREE, 0, 1'b0, 1, 0, 5);
    drain();
    live_handles.delete();

    // Random phases under several settings, free lists kept consistent per phase.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_classes(16, 40, 200, 4096, 4, 8, 3, 64);
        1: set_classes(300, 0, 100, 50, 1, 2, 2, 2);
        2: set_classes(8, 12, 20, 305, 2, 1, 5, 16);
        3: set_classes(4096, 4096, 4096, 4096, 64, 64, 64, 64);
        default: set_classes(5, 304, 1000, 3000, 3, 6, 9, 1);
      endcase
      for (int n = 0; n < 210;) begin
        burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        for (int b = 0; b < burst && n < 210; b++, n++) random_item();
        gap();
      end
      drain();
      live_handles.delete();
    end

    if (fail_count == 0) $display("[size_class_slab_allocator_top] OK");
    else $display("[size_class_slab_allocator_top] ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("[size_class_slab_allocator_top] ERROR");
    $finish;
  end
endmodule
